FILE: hdl/ogds_pkg.sv
// Shared types and constants for the oscillator discipline step core.
package ogds_pkg;

  // Alarm event codes.
  localparam logic [1:0] ALARM_NONE   = 2'd0;
  localparam logic [1:0] ALARM_RAISED = 2'd1;
  localparam logic [1:0] ALARM_CEASED = 2'd2;

  // Outcome codes.
  localparam logic [1:0] OUTCOME_CAL   = 2'd0;
  localparam logic [1:0] OUTCOME_NOFIX = 2'd1;
  localparam logic [1:0] OUTCOME_SKIP  = 2'd2;

  // Thresholds of the tuning policy.
  localparam int SIG_FACTOR      = 100;
  localparam int ACC_SAVE_MAX    = 10000;
  localparam int ERR_SAVE_MAX    = 2000;
  localparam int HOURS_PER_DAY   = 24;
  localparam int SECONDS_PER_DAY = 24 * 60 * 60;

  // Warning interval, reset value and derived limits.
  localparam int WARN_DAYS_RESET = 7;
  localparam int WARN_HOURS_W    = 13;
  localparam int WARN_SECS_W     = 25;
  localparam logic [WARN_HOURS_W-1:0] WARN_HOURS_RESET =
    WARN_HOURS_W'(WARN_DAYS_RESET * HOURS_PER_DAY);
  localparam logic [WARN_SECS_W-1:0] WARN_SECS_RESET =
    WARN_SECS_W'(WARN_DAYS_RESET * SECONDS_PER_DAY);

  // Gain 3/2000 = 3/(16*125); the division by 125 is a reciprocal multiply.
  // ceil(2^35/125) is exact for every dividend below 2^28.
  localparam int               DIV_IN_W   = 28;
  localparam int               RECIP_W    = 29;
  localparam logic [RECIP_W-1:0] RECIP_125 = 29'd274877907;
  localparam int               RECIP_SH   = 35;
  localparam int               QUOT_W     = 21;
  localparam int               PROD_W     = DIV_IN_W + RECIP_W;

  // One measurement request, less the DAC code (its width is a parameter).
  typedef struct packed {
    logic              fix_fault;
    logic signed [30:0] freq_error;
    logic [30:0]       meas_accuracy;
    logic [15:0]       integration_sec;
    logic [23:0]       uptime_hours;
    logic [31:0]       fix_time_sec;
  } item_t;

  // Decisions drawn from the correction path.
  typedef struct packed {
    logic changed;
    logic significant;
    logic small_acc;
    logic small_err;
  } corr_t;

  // Result flags, less the DAC code.
  typedef struct packed {
    logic       apply_dac;
    logic       save_dac;
    logic       restart_measure;
    logic [1:0] alarm_event;
    logic       store_fix;
    logic       fix_lost;
    logic [1:0] outcome;
  } flags_t;

endpackage

FILE: hdl/ogds_corr.sv
// Proportional DAC correction: gain, clamp and error tests, no state.
module ogds_corr
  import ogds_pkg::*;
#(
  parameter int DAC_BITS = 12
) (
  input  logic signed [30:0]   freq_error,
  input  logic [30:0]          meas_accuracy,
  input  logic [DAC_BITS-1:0]  dac_now,
  output logic [DAC_BITS-1:0]  dac_corr,
  output corr_t                corr
);

  localparam int SUM_W = QUOT_W + 1;
  localparam logic [SUM_W-1:0] DAC_MAX_EXT = SUM_W'((1 << DAC_BITS) - 1);

  logic [30:0]        err_bits;
  logic [30:0]        aerr;
  logic [31:0]        err_x3;
  logic [DIV_IN_W-1:0] div_in;
  logic [PROD_W-1:0]  prod;
  logic [QUOT_W-1:0]  qmag;
  logic [SUM_W-1:0]   up_sum;
  logic [37:0]        err_x100;

  // Magnitude of the error; the most negative value still fits unsigned.
  assign err_bits = freq_error;
  assign aerr     = err_bits[30] ? (~err_bits + 31'd1) : err_bits;

  // |error| * 3, then divide by 16 with a shift and by 125 with a reciprocal.
  assign err_x3 = {aerr, 1'b0} + {1'b0, aerr};
  assign div_in = err_x3[31:4];
  assign prod   = PROD_W'(div_in) * PROD_W'(RECIP_125);
  assign qmag   = prod[RECIP_SH +: QUOT_W];

  // Apply the correction against the error sign and clamp to the DAC range.
  assign up_sum = SUM_W'(dac_now) + SUM_W'(qmag);
  always_comb begin
    if (err_bits[30]) begin
      dac_corr = (up_sum > DAC_MAX_EXT) ? DAC_MAX_EXT[DAC_BITS-1:0] : up_sum[DAC_BITS-1:0];
    end else if (qmag > QUOT_W'(dac_now)) begin
      dac_corr = '0;
    end else begin
      dac_corr = dac_now - qmag[DAC_BITS-1:0];
    end
  end

  // 100 * |error| as shifts and adds.
  assign err_x100 = {1'b0, aerr, 6'b0} + {2'b0, aerr, 5'b0} + {5'b0, aerr, 2'b0};

  assign corr.changed     = (dac_corr != dac_now);
  assign corr.significant = (err_x100 > {7'b0, meas_accuracy});
  assign corr.small_acc   = (meas_accuracy <= 31'(ACC_SAVE_MAX));
  assign corr.small_err   = (aerr < 31'(ERR_SAVE_MAX));

endmodule

FILE: hdl/ogds_policy.sv
// Alarm, store and save policy with the discipline state and the warning register.
module ogds_policy
  import ogds_pkg::*;
#(
  parameter int DAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  logic                commit,
  input  item_t               item,
  input  logic [DAC_BITS-1:0] dac_now,
  input  logic [DAC_BITS-1:0] dac_corr,
  input  corr_t               corr,
  output logic [DAC_BITS-1:0] dac_next,
  output flags_t              flags
);

  logic [WARN_HOURS_W-1:0] warn_hours;
  logic [WARN_SECS_W-1:0]  warn_secs;
  logic                    warn_active;
  logic [23:0]             last_store_hours;
  logic [31:0]             last_fix_sec;
  logic [DAC_BITS-1:0]     saved_dac;
  logic                    saved_valid;

  logic                    warn_active_next;
  logic [23:0]             last_store_hours_next;
  logic [31:0]             last_fix_sec_next;
  logic [DAC_BITS-1:0]     saved_dac_next;
  logic                    saved_valid_next;

  logic [24:0]             hours_limit;
  logic                    uptime_hit;
  logic [32:0]             fix_diff;
  logic                    fix_hit;
  logic [DAC_BITS-1:0]     saved_eff;

  // Warning limits are kept in hours and seconds, scaled when written.
  always_ff @(posedge clk) begin
    if (rst) begin
      warn_hours <= WARN_HOURS_RESET;
      warn_secs  <= WARN_SECS_RESET;
    end else if (cfg_wr_en) begin
      warn_hours <= WARN_HOURS_W'(cfg_wr_data) * WARN_HOURS_W'(HOURS_PER_DAY);
      warn_secs  <= WARN_SECS_W'(cfg_wr_data) * WARN_SECS_W'(SECONDS_PER_DAY);
    end
  end

  // Fix-loss tests: uptime since the last store, or age of the last fix.
  assign hours_limit = {1'b0, last_store_hours} + 25'(warn_hours);
  assign uptime_hit  = ({1'b0, item.uptime_hours} >= hours_limit);
  assign fix_diff    = {1'b0, item.fix_time_sec} - {1'b0, last_fix_sec};
  assign fix_hit     = !fix_diff[32] && (fix_diff[31:0] > 32'(warn_secs));

  // The first calibration takes the current code as the saved one.
  assign saved_eff = saved_valid ? saved_dac : dac_now;

  // Decision logic for one request.
  always_comb begin
    warn_active_next      = warn_active;
    last_store_hours_next = last_store_hours;
    last_fix_sec_next     = last_fix_sec;
    saved_dac_next        = saved_dac;
    saved_valid_next      = saved_valid;
    dac_next              = dac_now;
    flags                 = '0;
    flags.alarm_event     = ALARM_NONE;
    flags.outcome         = OUTCOME_CAL;

    priority if (item.fix_fault) begin
      flags.outcome         = OUTCOME_NOFIX;
      flags.restart_measure = 1'b1;
      if ((uptime_hit || fix_hit) && !warn_active) begin
        warn_active_next  = 1'b1;
        flags.alarm_event = ALARM_RAISED;
      end
    end else if (item.integration_sec == '0) begin
      flags.outcome = OUTCOME_SKIP;
    end else begin
      dac_next = dac_corr;
      if (warn_active) begin
        warn_active_next  = 1'b0;
        flags.alarm_event = ALARM_CEASED;
      end
      if (warn_active || (item.uptime_hours > last_store_hours)) begin
        last_fix_sec_next     = item.fix_time_sec;
        last_store_hours_next = item.uptime_hours;
        flags.store_fix       = 1'b1;
      end
      saved_valid_next = 1'b1;
      saved_dac_next   = saved_eff;
      if (corr.changed && corr.significant) begin
        flags.apply_dac       = 1'b1;
        flags.restart_measure = 1'b1;
      end else if (corr.small_acc) begin
        flags.restart_measure = 1'b1;
        if ((dac_now != saved_eff) && corr.small_err) begin
          flags.save_dac = 1'b1;
          saved_dac_next = dac_now;
        end
      end
    end

    flags.fix_lost = warn_active_next;
  end

  // State moves only when the request's result is registered.
  always_ff @(posedge clk) begin
    if (rst) begin
      warn_active      <= 1'b0;
      last_store_hours <= '0;
      last_fix_sec     <= '0;
      saved_dac        <= '0;
      saved_valid      <= 1'b0;
    end else if (commit) begin
      warn_active      <= warn_active_next;
      last_store_hours <= last_store_hours_next;
      last_fix_sec     <= last_fix_sec_next;
      saved_dac        <= saved_dac_next;
      saved_valid      <= saved_valid_next;
    end
  end

  // A new code is only applied on a calibrated request.
  assert property (@(posedge clk) disable iff (rst)
    flags.apply_dac |-> (flags.outcome == OUTCOME_CAL) && flags.restart_measure)
    else $error("apply_dac outside a calibrated request");

  // Applying and saving exclude each other.
  assert property (@(posedge clk) disable iff (rst)
    !(flags.apply_dac && flags.save_dac))
    else $error("apply_dac and save_dac together");

  // A raised alarm stays raised into the next request.
  assert property (@(posedge clk) disable iff (rst)
    (commit && (flags.alarm_event == ALARM_RAISED)) |=> warn_active)
    else $error("alarm raised but state not set");

  // A calibrated request always leaves the alarm cleared.
  assert property (@(posedge clk) disable iff (rst)
    (commit && (flags.outcome == OUTCOME_CAL)) |=> !warn_active)
    else $error("alarm still active after calibration");

  // After the first committed calibration a saved code exists.
  assert property (@(posedge clk) disable iff (rst)
    (commit && (flags.outcome == OUTCOME_CAL)) |=> saved_valid)
    else $error("saved code not marked valid");

endmodule

FILE: hdl/ocxo_gps_discipline_step_core.sv
// Top level of the oscillator discipline step core: request and result registers.
// One measurement request is accepted every clock cycle while the input register is empty
// or the result register is free; it waits in the input register, then takes one
// combinational pass of the gain multiply, clamp and policy into the result register.
// The rate is set by the alarm and store state, which is read and updated in that single
// pass so that each request sees the state left by the one before. Results wait in the
// output register while out_ready is low, and one further request may wait in the input
// register behind it. warn_days is written through cfg_wr_en and cfg_wr_data and
// resets to seven days.
module ocxo_gps_discipline_step_core
  import ogds_pkg::*;
#(
  parameter int DAC_BITS = 12
) (
  input  logic                clk,
  input  logic                rst,
  // Configuration
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  // Measurement requests
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                fix_fault,
  input  logic signed [30:0]  freq_error,
  input  logic [30:0]         meas_accuracy,
  input  logic [15:0]         integration_sec,
  input  logic [DAC_BITS-1:0] dac_now,
  input  logic [23:0]         uptime_hours,
  input  logic [31:0]         fix_time_sec,
  // Results
  output logic                out_valid,
  input  logic                out_ready,
  output logic [DAC_BITS-1:0] dac_next,
  output logic                apply_dac,
  output logic                save_dac,
  output logic                restart_measure,
  output logic [1:0]          alarm_event,
  output logic                store_fix,
  output logic                fix_lost,
  output logic [1:0]          outcome
);

  logic                s1_valid;
  item_t               s1_item;
  logic [DAC_BITS-1:0] s1_dac;
  logic                out_adv;
  logic                commit;
  logic                in_accept;
  logic [DAC_BITS-1:0] corr_dac;
  corr_t               corr;
  logic [DAC_BITS-1:0] res_dac;
  flags_t              res_flags;

  // Handshake: the result register frees when empty or taken.
  assign out_adv   = !out_valid || out_ready;
  assign commit    = s1_valid && out_adv;
  assign in_ready  = !s1_valid || out_adv;
  assign in_accept = in_valid && in_ready;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (commit) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item.fix_fault       <= fix_fault;
      s1_item.freq_error      <= freq_error;
      s1_item.meas_accuracy   <= meas_accuracy;
      s1_item.integration_sec <= integration_sec;
      s1_item.uptime_hours    <= uptime_hours;
      s1_item.fix_time_sec    <= fix_time_sec;
      s1_dac                  <= dac_now;
    end
  end

  // Correction path.
  ogds_corr #(
    .DAC_BITS (DAC_BITS)
  ) u_corr (
    .freq_error    (s1_item.freq_error),
    .meas_accuracy (s1_item.meas_accuracy),
    .dac_now       (s1_dac),
    .dac_corr      (corr_dac),
    .corr          (corr)
  );

  // Policy and state.
  ogds_policy #(
    .DAC_BITS (DAC_BITS)
  ) u_policy (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .commit      (commit),
    .item        (s1_item),
    .dac_now     (s1_dac),
    .dac_corr    (corr_dac),
    .corr        (corr),
    .dac_next    (res_dac),
    .flags       (res_flags)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      dac_next        <= res_dac;
      apply_dac       <= res_flags.apply_dac;
      save_dac        <= res_flags.save_dac;
      restart_measure <= res_flags.restart_measure;
      alarm_event     <= res_flags.alarm_event;
      store_fix       <= res_flags.store_fix;
      fix_lost        <= res_flags.fix_lost;
      outcome         <= res_flags.outcome;
    end
  end

endmodule
